// ----- hw/rtl/fftns_pkg.sv -----
// Package with the types, codes and constants of the first-fit note track splitter.
`default_nettype none

package fftns_pkg;

   localparam int TIME_W         = 24;
   localparam int TRACK_INDEX_W  = 6;
   localparam int COUNT_W        = 7;
   localparam int MAX_TRACKS_DEF = 16;

   localparam logic CMD_PLACE     = 1'b0;
   localparam logic CMD_CLEAR     = 1'b1;
   localparam logic WORD_PAUSE    = 1'b0;
   localparam logic WORD_NOTE     = 1'b1;
   localparam logic STATUS_PLACED = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   localparam logic signed [7:0] PAUSE_TONE = -8'sd1;

   typedef struct packed {
      logic                     command;
      logic signed [TIME_W-1:0] note_start;
      logic signed [TIME_W-1:0] note_length;
      logic [6:0]               tone;
      logic [6:0]               volume;
      logic [15:0]              label_tag;
      logic                     has_label;
      logic                     is_control;
   } req_type;

   typedef struct packed {
      logic [TRACK_INDEX_W-1:0] track_index;
      logic                     word_kind;
      logic [TIME_W-1:0]        word_length;
      logic signed [7:0]        out_tone;
      logic [6:0]               out_volume;
      logic [15:0]              out_label_tag;
      logic                     opened_track;
      logic                     status;
      logic                     last;
      logic [COUNT_W-1:0]       tracks_in_use;
   } rsp_type;

   // Search result handed from one cell to the next along the chain.
   typedef struct packed {
      logic                     found;
      logic                     fresh;
      logic [TIME_W-1:0]        end_time;
      logic [TRACK_INDEX_W-1:0] index;
   } link_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              clear;
      logic              commit;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] new_end;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SECOND
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fftns_cell.sv -----
// One track cell: holds a track's end time and open flag and takes part in the first-fit chain.
`default_nettype none

module fftns_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  fftns_pkg::cell_ctrl_type ctrl,
   input  fftns_pkg::link_type    link_in,
   output fftns_pkg::link_type    link_out
);

   logic                          open_ff;
   logic                          open_in;
   logic [fftns_pkg::TIME_W-1:0]  end_ff;
   logic [fftns_pkg::TIME_W-1:0]  end_in;
   logic                          fit;
   logic                          claim;

   always_comb begin
      fit   = open_ff && (end_ff <= ctrl.start);
      claim = !link_in.found && (fit || !open_ff);

      link_out.found = link_in.found || fit || !open_ff;
      if (claim) begin
         link_out.fresh    = !open_ff;
         link_out.end_time = open_ff ? end_ff : '0;
         link_out.index    = fftns_pkg::TRACK_INDEX_W'(CELL_INDEX);
      end else begin
         link_out.fresh    = link_in.fresh;
         link_out.end_time = link_in.end_time;
         link_out.index    = link_in.index;
      end

      open_in = open_ff;
      end_in  = end_ff;
      if (ctrl.clear) begin
         open_in = 1'b0;
      end else if (ctrl.commit && claim) begin
         open_in = 1'b1;
         end_in  = ctrl.new_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
      end_ff <= end_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_note_track_splitter.sv -----
// Top level of the first-fit note track splitter: sequencer, result register and cell chain.
// Notes must arrive on the req_ channel ordered by start time, one transaction each; the
// block does not enforce this. They are placed on up to MAX_TRACKS monophonic tracks,
// lowest fitting track first. A clear transaction (command set) empties every track and
// gives no result, as does a skipped note. A placed note gives a note result, preceded by
// a pause result when its track ends before the note starts; a note finding no free track
// gives one status result. Results leave on the rsp_ channel from a single output register.
// A transaction is taken at one clock edge into the note register, and the cell chain is
// searched and updated in a later cycle, once the output register is free, which loads the
// first result into the output register. A clear or skipped note is done when it is taken;
// a placed or dropped note loads its one result in the search step, and a note that needs
// a pause loads its pause result there and its note result, held in a second register,
// once the output register is free again.
// req_stall is high while a transaction is being worked on. When the receiver stalls,
// the output register holds its result and the sequencer waits; the next transaction
// is taken only after the last result of the current one has been loaded.
// Synchronous reset closes every track, empties the output register and returns the
// sequencer to idle.
`default_nettype none

module first_fit_note_track_splitter #(
   parameter int MAX_TRACKS = fftns_pkg::MAX_TRACKS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  fftns_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output fftns_pkg::rsp_type  rsp_data
);

   fftns_pkg::state_type                 state_ff;
   fftns_pkg::state_type                 state_in;
   fftns_pkg::req_type                   note_ff;
   fftns_pkg::req_type                   note_in;
   fftns_pkg::rsp_type                   rsp_ff;
   fftns_pkg::rsp_type                   rsp_in;
   fftns_pkg::rsp_type                   second_ff;
   fftns_pkg::rsp_type                   second_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [fftns_pkg::COUNT_W-1:0]        count_ff;
   logic [fftns_pkg::COUNT_W-1:0]        count_in;
   logic [fftns_pkg::COUNT_W-1:0]        count_next;
   fftns_pkg::cell_ctrl_type             ctrl;
   fftns_pkg::link_type                  links [0:MAX_TRACKS];
   fftns_pkg::link_type                  hit;
   logic                                 req_accept;
   logic                                 out_free;
   logic                                 note_ok;
   logic [fftns_pkg::TIME_W:0]           end_sum;
   logic [fftns_pkg::TIME_W-1:0]         gap;
   fftns_pkg::rsp_type                   pause_rsp;
   fftns_pkg::rsp_type                   note_rsp;
   fftns_pkg::rsp_type                   full_rsp;

   assign links[0] = '0;
   assign hit      = links[MAX_TRACKS];

   for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
      fftns_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .link_in  (links[g]),
         .link_out (links[g+1])
      );
   end

   always_comb begin
      req_stall  = (state_ff != fftns_pkg::ST_IDLE);
      req_accept = req_valid && !req_stall;
      out_free   = !rsp_valid_ff || !rsp_stall;
      note_ok    = req_data.has_label && !req_data.is_control &&
                   !req_data.note_start[fftns_pkg::TIME_W-1] &&
                   !req_data.note_length[fftns_pkg::TIME_W-1] &&
                   (req_data.note_length != '0);

      end_sum = {1'b0, note_ff.note_start} + {1'b0, note_ff.note_length};
      gap     = note_ff.note_start - hit.end_time;
      count_next = hit.fresh ? count_ff + fftns_pkg::COUNT_W'(1) : count_ff;

      ctrl.clear   = 1'b0;
      ctrl.commit  = 1'b0;
      ctrl.start   = note_ff.note_start;
      ctrl.new_end = end_sum[fftns_pkg::TIME_W] ? '1 : end_sum[fftns_pkg::TIME_W-1:0];

      pause_rsp.track_index   = hit.index;
      pause_rsp.word_kind     = fftns_pkg::WORD_PAUSE;
      pause_rsp.word_length   = gap;
      pause_rsp.out_tone      = fftns_pkg::PAUSE_TONE;
      pause_rsp.out_volume    = '0;
      pause_rsp.out_label_tag = '0;
      pause_rsp.opened_track  = hit.fresh;
      pause_rsp.status        = fftns_pkg::STATUS_PLACED;
      pause_rsp.last          = 1'b0;
      pause_rsp.tracks_in_use = count_next;

      note_rsp.track_index    = hit.index;
      note_rsp.word_kind      = fftns_pkg::WORD_NOTE;
      note_rsp.word_length    = note_ff.note_length;
      note_rsp.out_tone       = {1'b0, note_ff.tone};
      note_rsp.out_volume     = note_ff.volume;
      note_rsp.out_label_tag  = note_ff.label_tag;
      note_rsp.opened_track   = hit.fresh;
      note_rsp.status         = fftns_pkg::STATUS_PLACED;
      note_rsp.last           = 1'b1;
      note_rsp.tracks_in_use  = count_next;

      full_rsp               = '0;
      full_rsp.status        = fftns_pkg::STATUS_FULL;
      full_rsp.last          = 1'b1;
      full_rsp.tracks_in_use = count_ff;

      state_in     = state_ff;
      note_in      = note_ff;
      rsp_in       = rsp_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         fftns_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_data.command == fftns_pkg::CMD_CLEAR) begin
                  ctrl.clear = 1'b1;
                  count_in   = '0;
               end else if (note_ok) begin
                  note_in  = req_data;
                  state_in = fftns_pkg::ST_SEARCH;
               end
            end
         end
         fftns_pkg::ST_SEARCH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = fftns_pkg::ST_IDLE;
               if (!hit.found) begin
                  rsp_in = full_rsp;
               end else begin
                  ctrl.commit = 1'b1;
                  count_in    = count_next;
                  if (gap != '0) begin
                     rsp_in    = pause_rsp;
                     second_in = note_rsp;
                     state_in  = fftns_pkg::ST_SECOND;
                  end else begin
                     rsp_in = note_rsp;
                  end
               end
            end
         end
         fftns_pkg::ST_SECOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = second_ff;
               state_in     = fftns_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fftns_pkg::ST_IDLE;
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fftns_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      note_ff   <= note_in;
      rsp_ff    <= rsp_in;
      second_ff <= second_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fftns_pkg::COUNT_W'(MAX_TRACKS))
      else $error("Open track count exceeds the number of tracks.");

   a_second_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fftns_pkg::ST_SECOND) |-> rsp_valid_ff)
      else $error("Second result pending without a first result in the output register.");

   a_pause_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.word_kind == fftns_pkg::WORD_PAUSE &&
       rsp_data.status == fftns_pkg::STATUS_PLACED) |-> !rsp_data.last)
      else $error("Pause result marked as the final result of a transaction.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == fftns_pkg::STATUS_FULL) |->
      (rsp_data.tracks_in_use == fftns_pkg::COUNT_W'(MAX_TRACKS)))
      else $error("No-free-track status given while tracks remain unopened.");

endmodule

`default_nettype wire

// ----- tb/tb_first_fit_note_track_splitter.sv -----
// Self-checking testbench of the first-fit note track splitter, with its scoreboard.
`timescale 1ns / 100ps

module tb_first_fit_note_track_splitter;

   localparam int TRACK_LIMIT     = fftns_pkg::MAX_TRACKS_DEF;
   localparam int RUN_LIMIT       = 500000;
   localparam int ITEMS_PER_PHASE = 370;
   localparam int HOLD_CYCLES     = 300;
   localparam int TIME_POS_MAX    = 24'h7FFFFF;

   class track_scoreboard;
      logic [fftns_pkg::TIME_W-1:0] track_end [TRACK_LIMIT];
      int                           open_tracks;
      fftns_pkg::rsp_type           expected_words [$];
      int                           errors, accepted, notes, pauses, drops, clears, skipped;

      function new();
         clear_tracks();
         errors   = 0;
         accepted = 0;
         notes    = 0;
         pauses   = 0;
         drops    = 0;
         clears   = 0;
         skipped  = 0;
      endfunction

      function void clear_tracks();
         foreach (track_end[i]) track_end[i] = '0;
         open_tracks = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void queue_expected(fftns_pkg::rsp_type word);
         expected_words = {expected_words, word};
      endfunction

      function void take_request(fftns_pkg::req_type item);
         fftns_pkg::rsp_type           word;
         logic [fftns_pkg::TIME_W-1:0] start_t;
         logic [fftns_pkg::TIME_W-1:0] len_t;
         logic [fftns_pkg::TIME_W-1:0] gap;
         logic [fftns_pkg::TIME_W:0]   end_sum;
         int                           slot;
         logic                         opened;
         accepted++;
         word    = '0;
         slot    = -1;
         opened  = 1'b0;
         start_t = item.note_start;
         len_t   = item.note_length;
         if (item.command == fftns_pkg::CMD_CLEAR) begin
            clears++;
            clear_tracks();
            return;
         end
         if (!item.has_label || item.is_control || start_t[fftns_pkg::TIME_W-1]
             || len_t[fftns_pkg::TIME_W-1] || len_t == '0) begin
            skipped++;
            return;
         end
         for (int i = 0; i < open_tracks; i++) begin
            if (slot < 0 && track_end[i] <= start_t) slot = i;
         end
         if (slot < 0) begin
            if (open_tracks >= TRACK_LIMIT) begin
               word.status        = fftns_pkg::STATUS_FULL;
               word.last          = 1'b1;
               word.tracks_in_use = fftns_pkg::COUNT_W'(open_tracks);
               queue_expected(word);
               drops++;
               return;
            end
            slot            = open_tracks;
            track_end[slot] = '0;
            open_tracks++;
            opened          = 1'b1;
         end
         word.track_index   = fftns_pkg::TRACK_INDEX_W'(slot);
         word.opened_track  = opened;
         word.status        = fftns_pkg::STATUS_PLACED;
         word.tracks_in_use = fftns_pkg::COUNT_W'(open_tracks);
         gap = start_t - track_end[slot];
         if (gap != '0) begin
            word.word_kind     = fftns_pkg::WORD_PAUSE;
            word.word_length   = gap;
            word.out_tone      = fftns_pkg::PAUSE_TONE;
            word.out_volume    = '0;
            word.out_label_tag = '0;
            word.last          = 1'b0;
            queue_expected(word);
            pauses++;
         end
         end_sum = {1'b0, start_t} + {1'b0, len_t};
         track_end[slot] = end_sum[fftns_pkg::TIME_W] ? '1 : end_sum[fftns_pkg::TIME_W-1:0];
         word.word_kind     = fftns_pkg::WORD_NOTE;
         word.word_length   = len_t;
         word.out_tone      = {1'b0, item.tone};
         word.out_volume    = item.volume;
         word.out_label_tag = item.label_tag;
         word.last          = 1'b1;
         queue_expected(word);
         notes++;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_word(fftns_pkg::rsp_type got);
         fftns_pkg::rsp_type want;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with none expected", got));
            return;
         end
         want = expected_words.pop_front();
         check_field("track_index", got.track_index, want.track_index);
         check_field("word_kind", got.word_kind, want.word_kind);
         check_field("word_length", got.word_length, want.word_length);
         check_field("out_tone", got.out_tone, want.out_tone);
         check_field("out_volume", got.out_volume, want.out_volume);
         check_field("out_label_tag", got.out_label_tag, want.out_label_tag);
         check_field("opened_track", got.opened_track, want.opened_track);
         check_field("status", got.status, want.status);
         check_field("last", got.last, want.last);
         check_field("tracks_in_use", got.tracks_in_use, want.tracks_in_use);
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   fftns_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   fftns_pkg::rsp_type rsp_data;

   track_scoreboard board;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              receiver_hold;
   int              cycles;
   int              cursor;
   int              last_end;
   int              max_step;
   int              max_len;

   first_fit_note_track_splitter #(
      .MAX_TRACKS(TRACK_LIMIT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic fftns_pkg::req_type make_note(int start, int len, int tone_v, int vol_v,
                                                    int tag_v);
      fftns_pkg::req_type item;
      item             = '0;
      item.command     = fftns_pkg::CMD_PLACE;
      item.note_start  = start[fftns_pkg::TIME_W-1:0];
      item.note_length = len[fftns_pkg::TIME_W-1:0];
      item.tone        = tone_v[6:0];
      item.volume      = vol_v[6:0];
      item.label_tag   = tag_v[15:0];
      item.has_label   = 1'b1;
      item.is_control  = 1'b0;
      return item;
   endfunction

   function automatic fftns_pkg::req_type noise_item(logic command);
      fftns_pkg::req_type item;
      item.command     = command;
      item.note_start  = fftns_pkg::TIME_W'($urandom);
      item.note_length = fftns_pkg::TIME_W'($urandom);
      item.tone        = 7'($urandom);
      item.volume      = 7'($urandom);
      item.label_tag   = 16'($urandom);
      item.has_label   = 1'($urandom_range(0, 1));
      item.is_control  = 1'($urandom_range(0, 1));
      return item;
   endfunction

   function automatic fftns_pkg::req_type next_note();
      int len;
      if ($urandom_range(0, 99) < 15 && last_end >= cursor && last_end <= TIME_POS_MAX)
         cursor = last_end;
      else
         cursor += $urandom_range(0, max_step);
      if ($urandom_range(0, 99) < 2)
         len = $urandom_range(1, TIME_POS_MAX);
      else
         len = $urandom_range(1, max_len);
      last_end = cursor + len;
      return make_note(cursor, len, $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 65535));
   endfunction

   task automatic send_item(fftns_pkg::req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_request(item);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold > 0) begin
            hold_left     = receiver_hold;
            receiver_hold = 0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) board.check_word(rsp_data);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, board.pending());
      $display("** first_fit_note_track_splitter: FAILED **");
      $finish;
   end

   initial begin
      fftns_pkg::req_type item;
      int                 sent;
      int                 base;
      int                 roll;
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 32;
      recv_idle_pct = 79;
      receiver_hold = 0;
      cursor        = 0;
      last_end      = 0;
      max_step      = 40;
      max_len       = 250;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Opening notes, the skipped cases, a gapless fit, a pause, then every track filled.
      send_item(make_note(0, 10, 127, 127, 16'hFFFF));
      item = make_note(20, 5, 1, 1, 1);
      item.has_label = 1'b0;
      send_item(item);
      item.has_label  = 1'b1;
      item.is_control = 1'b1;
      send_item(item);
      send_item(make_note(24'h800000, 5, 2, 2, 2));
      send_item(make_note(20, 0, 3, 3, 3));
      send_item(make_note(20, 24'hFFFFFF, 4, 4, 4));
      send_item(make_note(10, 5, 0, 0, 0));
      send_item(make_note(20, 5, 64, 64, 16'h5A5A));
      send_item(make_note(21, 100, 99, 33, 16'hA5A5));
      for (int i = 0; i < 16; i++)
         send_item(make_note(30, TIME_POS_MAX, i * 8, 127 - i * 8, i));
      send_item(noise_item(fftns_pkg::CMD_CLEAR));
      send_item(make_note(TIME_POS_MAX, TIME_POS_MAX, 127, 0, 16'h8001));
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         base = board.accepted - board.skipped;
         while (board.accepted - board.skipped - base < ITEMS_PER_PHASE) begin
            if (sent % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0: max_step = 2;
                  1: max_step = 40;
                  default: max_step = 600;
               endcase
               case ($urandom_range(0, 2))
                  0: max_len = 12;
                  1: max_len = 250;
                  default: max_len = 4000;
               endcase
            end
            if (phase == 0 && sent == 150) receiver_hold = HOLD_CYCLES;
            roll = $urandom_range(0, 99);
            if (cursor > 24'h7F0000 || roll < 3) begin
               send_item(noise_item(fftns_pkg::CMD_CLEAR));
               cursor   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'h7F0000) : 0;
               last_end = 0;
            end else if (roll < 12) begin
               send_item(noise_item(fftns_pkg::CMD_PLACE));
            end else begin
               send_item(next_note());
            end
            sent++;
         end
         drain_results();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d transactions: %0d notes placed, %0d pauses, %0d dropped on full",
               board.accepted, board.notes, board.pauses, board.drops);
      $display("tracks, %0d clears and %0d skipped notes, with %0d mismatches.",
               board.clears, board.skipped, board.errors);
      if (board.errors == 0) begin
         $display("** first_fit_note_track_splitter: PASSED **");
      end else begin
         $display("** first_fit_note_track_splitter: FAILED **");
      end
      $finish;
   end

endmodule
